/* hw/rtl/cpsd_pkg.sv */
// Package for the cart-pole step discretizer: shared types, codes and the step microprogram.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package cpsd_pkg;

    localparam int DEF_FRAC_BITS          = 16;
    localparam int DEF_TRIG_TABLE_ENTRIES = 1024;

    localparam int CFG_W      = 23;
    localparam int STEPS_W    = 11;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 144;

    localparam logic REG_FORCE_MAGNITUDE = 1'b0;
    localparam logic REG_MAX_STEPS       = 1'b1;

    localparam logic [2:0] OP_MUL  = 3'd0;
    localparam logic [2:0] OP_DIV  = 3'd1;
    localparam logic [2:0] OP_ADD  = 3'd2;
    localparam logic [2:0] OP_SUB  = 3'd3;
    localparam logic [2:0] OP_TRIG = 3'd4;

    localparam logic [4:0] SRC_POS   = 5'd0;
    localparam logic [4:0] SRC_VEL   = 5'd1;
    localparam logic [4:0] SRC_ANG   = 5'd2;
    localparam logic [4:0] SRC_RATE  = 5'd3;
    localparam logic [4:0] SRC_SIN   = 5'd4;
    localparam logic [4:0] SRC_COS   = 5'd5;
    localparam logic [4:0] SRC_T0    = 5'd6;
    localparam logic [4:0] SRC_T1    = 5'd7;
    localparam logic [4:0] SRC_T2    = 5'd8;
    localparam logic [4:0] SRC_T3    = 5'd9;
    localparam logic [4:0] SRC_FORCE = 5'd10;
    localparam logic [4:0] SRC_K_ML  = 5'd11;
    localparam logic [4:0] SRC_K_TOT = 5'd12;
    localparam logic [4:0] SRC_K_G   = 5'd13;
    localparam logic [4:0] SRC_K_TEN = 5'd14;
    localparam logic [4:0] SRC_K_HLF = 5'd15;
    localparam logic [4:0] SRC_K_43  = 5'd16;
    localparam logic [4:0] SRC_K_100 = 5'd17;
    localparam logic [4:0] SRC_K_50  = 5'd18;

    localparam logic [4:0] PROG_LAST = 5'd30;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] src_a;
        logic [4:0] src_b;
        logic [4:0] dst;
    } ucmd_t;

    typedef struct packed {
        logic  accept;
        logic  start;
        logic  upd;
        logic  load;
        ucmd_t cmd;
    } ctl_t;

    typedef struct packed {
        logic done;
        logic out_free;
    } status_t;

    function automatic ucmd_t uw(logic [2:0] op, logic [4:0] a, logic [4:0] b, logic [4:0] d);
        ucmd_t w;
        w.op    = op;
        w.src_a = a;
        w.src_b = b;
        w.dst   = d;
        return w;
    endfunction

    function automatic ucmd_t prog_word(logic [4:0] pc);
        ucmd_t w;
        case (pc)
            5'd0:  w = uw(OP_TRIG, SRC_ANG, SRC_ANG, SRC_T0);
            5'd1:  w = uw(OP_MUL, SRC_RATE, SRC_RATE, SRC_T0);
            5'd2:  w = uw(OP_MUL, SRC_K_ML, SRC_T0, SRC_T0);
            5'd3:  w = uw(OP_MUL, SRC_T0, SRC_SIN, SRC_T0);
            5'd4:  w = uw(OP_ADD, SRC_FORCE, SRC_T0, SRC_T0);
            5'd5:  w = uw(OP_DIV, SRC_T0, SRC_K_TOT, SRC_T1);
            5'd6:  w = uw(OP_MUL, SRC_K_G, SRC_SIN, SRC_T0);
            5'd7:  w = uw(OP_MUL, SRC_COS, SRC_T1, SRC_T2);
            5'd8:  w = uw(OP_SUB, SRC_T0, SRC_T2, SRC_T0);
            5'd9:  w = uw(OP_MUL, SRC_COS, SRC_COS, SRC_T2);
            5'd10: w = uw(OP_MUL, SRC_K_TEN, SRC_T2, SRC_T2);
            5'd11: w = uw(OP_DIV, SRC_T2, SRC_K_TOT, SRC_T2);
            5'd12: w = uw(OP_SUB, SRC_K_43, SRC_T2, SRC_T2);
            5'd13: w = uw(OP_MUL, SRC_K_HLF, SRC_T2, SRC_T2);
            5'd14: w = uw(OP_DIV, SRC_T0, SRC_T2, SRC_T0);
            5'd15: w = uw(OP_MUL, SRC_K_ML, SRC_T0, SRC_T2);
            5'd16: w = uw(OP_MUL, SRC_T2, SRC_COS, SRC_T2);
            5'd17: w = uw(OP_DIV, SRC_T2, SRC_K_TOT, SRC_T2);
            5'd18: w = uw(OP_SUB, SRC_T1, SRC_T2, SRC_T1);
            5'd19: w = uw(OP_MUL, SRC_T1, SRC_K_100, SRC_T2);
            5'd20: w = uw(OP_ADD, SRC_VEL, SRC_T2, SRC_T2);
            5'd21: w = uw(OP_MUL, SRC_T2, SRC_K_50, SRC_T2);
            5'd22: w = uw(OP_MUL, SRC_T1, SRC_K_50, SRC_T3);
            5'd23: w = uw(OP_ADD, SRC_POS, SRC_T2, SRC_POS);
            5'd24: w = uw(OP_ADD, SRC_VEL, SRC_T3, SRC_VEL);
            5'd25: w = uw(OP_MUL, SRC_T0, SRC_K_100, SRC_T2);
            5'd26: w = uw(OP_ADD, SRC_RATE, SRC_T2, SRC_T2);
            5'd27: w = uw(OP_MUL, SRC_T2, SRC_K_50, SRC_T2);
            5'd28: w = uw(OP_MUL, SRC_T0, SRC_K_50, SRC_T3);
            5'd29: w = uw(OP_ADD, SRC_ANG, SRC_T2, SRC_ANG);
            5'd30: w = uw(OP_ADD, SRC_RATE, SRC_T3, SRC_RATE);
            default: w = uw(OP_ADD, SRC_T0, SRC_T0, SRC_T0);
        endcase
        return w;
    endfunction

    // Applies a sign to a magnitude and saturates to the signed 32-bit range.
    function automatic logic [31:0] sat_mag(logic neg, logic [63:0] m);
        logic [31:0] r;
        if (!neg) begin
            r = (m > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
        end else begin
            r = (m > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : (32'd0 - m[31:0]);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/cpsd_ctrl.sv */
// Controller of the cart-pole step discretizer: walks the step microprogram.
// Depends on cpsd_pkg; drives the datapath through ctl_t and reads status_t.
`default_nettype none
module cpsd_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic              s_tuser,
    input  wire cpsd_pkg::status_t sts,
    output cpsd_pkg::ctl_t         ctl
);
    import cpsd_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_UPD   = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [4:0] pc_reg, pc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        s_tready   = 1'b0;
        ctl.accept = 1'b0;
        ctl.start  = 1'b0;
        ctl.upd    = 1'b0;
        ctl.load   = 1'b0;
        ctl.cmd    = prog_word(pc_reg);
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctl.accept = 1'b1;
                    pc_next    = '0;
                    state_next = s_tuser ? ST_ISSUE : ST_UPD;
                end
            end
            ST_ISSUE: begin
                ctl.start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (sts.done) begin
                    if (pc_reg == PROG_LAST) begin
                        state_next = ST_UPD;
                    end else begin
                        pc_next    = pc_reg + 5'd1;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_UPD: begin
                ctl.upd    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    ctl.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/cpsd_datapath.sv */
// Datapath of the cart-pole step discretizer: state, shared multiplier, serial divider,
// sine table, box classifier and output register. Depends on cpsd_pkg; driven by cpsd_ctrl.
`default_nettype none
module cpsd_datapath #(
    parameter int FRAC_BITS          = cpsd_pkg::DEF_FRAC_BITS,
    parameter int TRIG_TABLE_ENTRIES = cpsd_pkg::DEF_TRIG_TABLE_ENTRIES
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire cpsd_pkg::ctl_t                   ctl,
    output cpsd_pkg::status_t                     sts,
    input  wire logic                             in_kind,
    input  wire logic                             in_push,
    input  wire logic                             cfg_wr_en,
    input  wire logic                             cfg_index,
    input  wire logic [cpsd_pkg::CFG_W-1:0]       cfg_wdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [cpsd_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import cpsd_pkg::*;

    localparam int     F    = FRAC_BITS;
    localparam int     LOG  = $clog2(TRIG_TABLE_ENTRIES);
    localparam int     AW   = $clog2(TRIG_TABLE_ENTRIES + 1);
    localparam int     NW   = FRAC_BITS + 33;
    localparam int     CW   = $clog2(NW + 1);
    localparam longint PIH_Q30 = 64'd1686629713;
    localparam logic [29:0] TWO_OVER_PI_Q30 = 30'd683565276;
    localparam longint ONE_L = 64'd1;

    localparam logic signed [31:0] K_ML  = 32'(((ONE_L << F) + 10) / 20);
    localparam logic signed [31:0] K_TOT = 32'(((ONE_L * 11 << F) + 5) / 10);
    localparam logic signed [31:0] K_G   = 32'(((ONE_L * 49 << F) + 2) / 5);
    localparam logic signed [31:0] K_TEN = 32'(((ONE_L << F) + 5) / 10);
    localparam logic signed [31:0] K_HLF = 32'(((ONE_L << F) + 1) / 2);
    localparam logic signed [31:0] K_43  = 32'(((ONE_L * 4 << F) + 1) / 3);
    localparam logic signed [31:0] K_100 = 32'(((ONE_L << F) + 50) / 100);
    localparam logic signed [31:0] K_50  = 32'(((ONE_L << F) + 25) / 50);
    localparam logic signed [31:0] LIM_X = 32'(ONE_L * 3 << F);
    localparam logic signed [31:0] ONE_X = 32'(ONE_L << F);
    localparam logic signed [31:0] VB    = 32'(((ONE_L * 3 << F) + 2) / 5);
    localparam logic signed [31:0] FA    = 32'((PIH_Q30 + (ONE_L << (29 - F))) >>> (30 - F));
    localparam logic signed [31:0] A15   =
        32'(((PIH_Q30 / 15) + (ONE_L << (29 - F))) >>> (30 - F));
    localparam logic signed [31:0] A90   =
        32'(((PIH_Q30 / 90) + (ONE_L << (29 - F))) >>> (30 - F));
    localparam logic signed [31:0] R2    =
        32'(((PIH_Q30 / 2) + (ONE_L << (29 - F))) >>> (30 - F));

    localparam int SH_L = (F >= 16) ? F - 16 : 0;
    localparam int SH_R = (F < 16) ? 16 - F : 0;
    localparam logic [39:0] F_RND = (SH_R > 0) ? (40'd1 << (SH_R - 1)) : 40'd0;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_MUL    = 3'd1;
    localparam logic [2:0] PH_DIV    = 3'd2;
    localparam logic [2:0] PH_DIVFIN = 3'd3;
    localparam logic [2:0] PH_TQ     = 3'd4;
    localparam logic [2:0] PH_TS1    = 3'd5;
    localparam logic [2:0] PH_TS2    = 3'd6;
    localparam logic [2:0] PH_TC     = 3'd7;

    function automatic logic [F:0] sine_entry(int r);
        logic [63:0] x, x2, term, sum, v;
        x    = 64'(r) * 64'(PIH_Q30) / 64'(TRIG_TABLE_ENTRIES);
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int k = 1; k <= 5; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1) sum = sum - term;
            else sum = sum + term;
        end
        v = (sum + (64'd1 << (29 - F))) >> (30 - F);
        if (v > (64'd1 << F)) v = 64'd1 << F;
        return v[F:0];
    endfunction

    logic [F:0] sine_rom [TRIG_TABLE_ENTRIES+1];
    for (genvar g = 0; g <= TRIG_TABLE_ENTRIES; g++) begin : g_rom
        assign sine_rom[g] = sine_entry(g);
    end

    logic signed [31:0] pos_reg, vel_reg, ang_reg, rate_reg, sin_reg, cos_reg;
    logic signed [31:0] t0_reg, t1_reg, t2_reg, t3_reg;
    logic [STEPS_W-1:0] step_cnt_reg;
    logic [CFG_W-1:0]   force_mag_reg;
    logic [STEPS_W-1:0] max_steps_reg;
    logic               stepped_reg, push_reg;
    logic [2:0]         ph_reg;
    logic               done_reg;
    logic signed [63:0] prod_reg;
    logic [61:0]        tprod_reg;
    logic               theta_neg_reg;
    logic [1:0]         quad_reg;
    logic [LOG-1:0]     r_reg;
    logic [AW-1:0]      rom_addr_reg;
    logic [F:0]         rom_data_reg;
    logic [NW-1:0]      nq_reg;
    logic [32:0]        rem_reg;
    logic [32:0]        den_reg;
    logic               dneg_reg;
    logic [CW-1:0]      dcnt_reg;
    logic               out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_reg;

    logic signed [31:0] force_val, opa, opb;
    logic [39:0]        fext;
    logic [31:0]        fsat;

    always_comb begin
        fext = ((40'(force_mag_reg) << SH_L) + F_RND) >> SH_R;
        fsat = (fext > 40'h00_7FFF_FFFF) ? 32'h7FFF_FFFF : fext[31:0];
        force_val = push_reg ? $signed(fsat) : $signed(32'd0 - fsat);
    end

    function automatic logic signed [31:0] sel(logic [4:0] code);
        logic signed [31:0] v;
        case (code)
            SRC_POS:   v = pos_reg;
            SRC_VEL:   v = vel_reg;
            SRC_ANG:   v = ang_reg;
            SRC_RATE:  v = rate_reg;
            SRC_SIN:   v = sin_reg;
            SRC_COS:   v = cos_reg;
            SRC_T0:    v = t0_reg;
            SRC_T1:    v = t1_reg;
            SRC_T2:    v = t2_reg;
            SRC_T3:    v = t3_reg;
            SRC_FORCE: v = force_val;
            SRC_K_ML:  v = K_ML;
            SRC_K_TOT: v = K_TOT;
            SRC_K_G:   v = K_G;
            SRC_K_TEN: v = K_TEN;
            SRC_K_HLF: v = K_HLF;
            SRC_K_43:  v = K_43;
            SRC_K_100: v = K_100;
            SRC_K_50:  v = K_50;
            default:   v = '0;
        endcase
        return v;
    endfunction

    assign opa = sel(ctl.cmd.src_a);
    assign opb = sel(ctl.cmd.src_b);

    logic [31:0]        mag_a, mag_b;
    logic [63:0]        mul_mag, mul_rnd;
    logic [31:0]        mul_res, div_res, zdiv_res, add_res;
    logic [32:0]        q_cap;
    logic signed [32:0] s33;
    logic [33:0]        rem_sh;
    logic               rem_ge;
    logic               wr_en;
    logic [31:0]        wr_val;
    logic [33:0]        tq;
    logic [63:0]        tu;
    logic [1:0]         tquad, cquad;
    logic [LOG-1:0]     tr;

    always_comb begin
        mag_a   = opa[31] ? (32'd0 - opa) : opa;
        mag_b   = opb[31] ? (32'd0 - opb) : opb;
        mul_mag = prod_reg[63] ? (64'd0 - prod_reg) : prod_reg;
        mul_rnd = (mul_mag + (64'd1 << (F - 1))) >> F;
        mul_res = sat_mag(prod_reg[63], mul_rnd);
        q_cap   = (nq_reg > (NW'(1) << 32)) ? 33'h1_0000_0000 : nq_reg[32:0];
        div_res = sat_mag(dneg_reg, 64'(q_cap));
        zdiv_res = opa[31] ? 32'h8000_0000 : ((opa != 0) ? 32'h7FFF_FFFF : 32'd0);
        if (ctl.cmd.op == OP_SUB) s33 = {opa[31], opa} - {opb[31], opb};
        else s33 = {opa[31], opa} + {opb[31], opb};
        if (s33[32] != s33[31]) add_res = s33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else add_res = s33[31:0];
        rem_sh = {rem_reg, nq_reg[NW-1]};
        rem_ge = rem_sh >= {1'b0, den_reg};
        tq     = 34'((64'(tprod_reg) + (64'd1 << 29)) >> 30);
        tu     = ((64'(tq) << LOG) + (64'd1 << (F - 1))) >> F;
        tquad  = tu[LOG+1:LOG];
        tr     = tu[LOG-1:0];
        cquad  = quad_reg + 2'd1;
        wr_en  = 1'b0;
        wr_val = '0;
        if (ctl.start && (ctl.cmd.op == OP_ADD || ctl.cmd.op == OP_SUB)) begin
            wr_en  = 1'b1;
            wr_val = add_res;
        end else if (ctl.start && ctl.cmd.op == OP_DIV && opb == 0) begin
            wr_en  = 1'b1;
            wr_val = zdiv_res;
        end else if (ph_reg == PH_MUL) begin
            wr_en  = 1'b1;
            wr_val = mul_res;
        end else if (ph_reg == PH_DIVFIN) begin
            wr_en  = 1'b1;
            wr_val = div_res;
        end
    end

    always_ff @(posedge aclk) begin
        rom_data_reg <= sine_rom[rom_addr_reg];
        if (!aresetn) begin
            ph_reg        <= PH_IDLE;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            force_mag_reg <= CFG_W'(655360);
            max_steps_reg <= STEPS_W'(1010);
            pos_reg       <= '0;
            vel_reg       <= '0;
            ang_reg       <= '0;
            rate_reg      <= '0;
            step_cnt_reg  <= '0;
        end else begin
            done_reg <= wr_en || (ph_reg == PH_TC);
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_FORCE_MAGNITUDE: force_mag_reg <= cfg_wdata;
                    REG_MAX_STEPS:       max_steps_reg <= cfg_wdata[STEPS_W-1:0];
                    default: ;
                endcase
            end
            if (ctl.accept) begin
                stepped_reg <= in_kind;
                push_reg    <= in_push;
            end
            if (wr_en) begin
                case (ctl.cmd.dst)
                    SRC_POS:  pos_reg  <= wr_val;
                    SRC_VEL:  vel_reg  <= wr_val;
                    SRC_ANG:  ang_reg  <= wr_val;
                    SRC_RATE: rate_reg <= wr_val;
                    SRC_T0:   t0_reg   <= wr_val;
                    SRC_T1:   t1_reg   <= wr_val;
                    SRC_T2:   t2_reg   <= wr_val;
                    SRC_T3:   t3_reg   <= wr_val;
                    default: ;
                endcase
            end
            case (ph_reg)
                PH_IDLE: begin
                    if (ctl.start) begin
                        case (ctl.cmd.op)
                            OP_MUL: begin
                                prod_reg <= opa * opb;
                                ph_reg   <= PH_MUL;
                            end
                            OP_DIV: begin
                                if (opb != 0) begin
                                    nq_reg   <= (NW'(mag_a) << (F + 1)) + NW'(mag_b);
                                    den_reg  <= {mag_b, 1'b0};
                                    rem_reg  <= '0;
                                    dneg_reg <= opa[31] ^ opb[31];
                                    dcnt_reg <= CW'(NW);
                                    ph_reg   <= PH_DIV;
                                end
                            end
                            OP_TRIG: begin
                                tprod_reg     <= 62'(mag_a) * 62'(TWO_OVER_PI_Q30);
                                theta_neg_reg <= opa[31];
                                ph_reg        <= PH_TQ;
                            end
                            default: ;
                        endcase
                    end
                end
                PH_MUL: ph_reg <= PH_IDLE;
                PH_DIV: begin
                    rem_reg  <= rem_ge ? 33'(rem_sh - {1'b0, den_reg}) : rem_sh[32:0];
                    nq_reg   <= {nq_reg[NW-2:0], rem_ge};
                    dcnt_reg <= dcnt_reg - CW'(1);
                    if (dcnt_reg == CW'(1)) ph_reg <= PH_DIVFIN;
                end
                PH_DIVFIN: ph_reg <= PH_IDLE;
                PH_TQ: begin
                    quad_reg     <= tquad;
                    r_reg        <= tr;
                    rom_addr_reg <= tquad[0] ? (AW'(TRIG_TABLE_ENTRIES) - AW'(tr)) : AW'(tr);
                    ph_reg       <= PH_TS1;
                end
                PH_TS1: begin
                    rom_addr_reg <= quad_reg[0] ? AW'(r_reg)
                                                : (AW'(TRIG_TABLE_ENTRIES) - AW'(r_reg));
                    ph_reg       <= PH_TS2;
                end
                PH_TS2: begin
                    sin_reg <= (quad_reg[1] ^ theta_neg_reg) ? (32'd0 - 32'(rom_data_reg))
                                                              : 32'(rom_data_reg);
                    ph_reg  <= PH_TC;
                end
                PH_TC: begin
                    cos_reg <= cquad[1] ? (32'd0 - 32'(rom_data_reg)) : 32'(rom_data_reg);
                    ph_reg  <= PH_IDLE;
                end
                default: ph_reg <= PH_IDLE;
            endcase
            if (ctl.upd) begin
                if (!stepped_reg) begin
                    pos_reg      <= '0;
                    vel_reg      <= '0;
                    ang_reg      <= '0;
                    rate_reg     <= '0;
                    step_cnt_reg <= '0;
                end else if (step_cnt_reg != '1) begin
                    step_cnt_reg <= step_cnt_reg + STEPS_W'(1);
                end
            end
            if (ctl.load) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    logic       failed, time_up, reward;
    logic [7:0] box;

    always_comb begin
        failed  = (pos_reg < -LIM_X) || (pos_reg > LIM_X) || (ang_reg < -FA) || (ang_reg > FA);
        time_up = step_cnt_reg > max_steps_reg;
        reward  = stepped_reg && !failed && !time_up;
        if (pos_reg < -ONE_X) box = 8'd0;
        else if (pos_reg < ONE_X) box = 8'd1;
        else box = 8'd2;
        if (vel_reg < -VB) box = box;
        else if (vel_reg < VB) box = box + 8'd3;
        else box = box + 8'd6;
        if (ang_reg < -A15) box = box;
        else if (ang_reg < -A90) box = box + 8'd9;
        else if (ang_reg < 0) box = box + 8'd18;
        else if (ang_reg < A90) box = box + 8'd27;
        else if (ang_reg < A15) box = box + 8'd36;
        else box = box + 8'd45;
        if (rate_reg < -R2) box = box;
        else if (rate_reg < R2) box = box + 8'd54;
        else box = box + 8'd108;
        if (failed) box = 8'd0;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            out_reg <= {5'd0, rate_reg, ang_reg, vel_reg, pos_reg,
                        reward, time_up, failed, box};
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_reg;
    assign sts.done     = done_reg;
    assign sts.out_free = !out_valid_reg || m_tready;

endmodule
`default_nettype wire

/* hw/rtl/cart_pole_step_discretizer.sv */
// Top level of the cart-pole step discretizer: joins controller and datapath.
// Depends on cpsd_pkg, cpsd_ctrl and cpsd_datapath.
//
// The input channel takes one word per step: s_tuser selects a reset (0) or a time
// step (1), and s_tdata[0] chooses the push direction. Every accepted word yields
// exactly one result word on the output channel with the new state, its box, the
// failure and time-up flags and the reward.
// A reset word goes through acceptance, state update and output load only. A step word
// also runs the microprogram: four divides on the serial divider, sixteen multiplies
// on the shared 32x32 multiplier, ten adds, and a sine and cosine lookup in the
// quarter-wave table.
// A new input word is accepted as soon as the previous step has reached the output
// register, even while that result still waits on m_tready; the block holds its
// next result until the receiver takes the current one. Configuration writes take
// effect at once; the user must make them while the block is idle (not enforced).
// After aresetn the state and step counter are zero, the force is 10 N and the step
// limit is 1010; no output word is pending.
`default_nettype none
module cart_pole_step_discretizer #(
    parameter int FRAC_BITS          = cpsd_pkg::DEF_FRAC_BITS,
    parameter int TRIG_TABLE_ENTRIES = cpsd_pkg::DEF_TRIG_TABLE_ENTRIES
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [cpsd_pkg::IN_TDATA_W-1:0]   s_tdata,  // push_right, zero fill
    input  wire logic                              s_tuser,  // kind
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // box_index[7:0], failed, time_up, reward, cart_position, cart_velocity,
    // pole_angle, pole_rate, zero fill
    output logic [cpsd_pkg::OUT_TDATA_W-1:0]       m_tdata,
    input  wire logic                              cfg_wr_en,
    input  wire logic                              cfg_index,
    input  wire logic [cpsd_pkg::CFG_W-1:0]        cfg_wdata
);
    import cpsd_pkg::*;

    ctl_t    ctl;
    status_t sts;

    cpsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .ctl      (ctl)
    );

    cpsd_datapath #(
        .FRAC_BITS          (FRAC_BITS),
        .TRIG_TABLE_ENTRIES (TRIG_TABLE_ENTRIES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .sts       (sts),
        .in_kind   (s_tuser),
        .in_push   (s_tdata[0]),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire

/* hw/rtl/cpsd_checker.sv */
// Port-level checker for the cart-pole step discretizer, bound to the top level.
// Depends on cpsd_pkg and cart_pole_step_discretizer.
`default_nettype none
module cpsd_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [cpsd_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import cpsd_pkg::*;

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output word pending after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    a_fail_box: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tdata[7:0] == 8'd0)
        else $error("failed word carries a nonzero box");

    a_reward: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10] |-> !m_tdata[8] && !m_tdata[9])
        else $error("reward given with failed or time-up");

    a_box_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:0] <= 8'd161)
        else $error("box index out of range");

endmodule

bind cart_pole_step_discretizer cpsd_checker u_cpsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
